// ===== src/ccfc_pkg.sv =====
package ccfc_pkg;

  // frame layout
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned MinFrame    = 8;

  // crc-32c, reflected castagnoli
  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_CRC_ERROR = 2'd2;

  // output queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] conv_id;
    logic [1:0]  status;
    logic        run_end;
  } result_t;

  // byte-wide crc update, an xor network after synthesis
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/ccfc_out_queue.sv =====
module ccfc_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en0,
  input  logic               wr_en1,
  input  ccfc_pkg::result_t  wr_data0,
  input  ccfc_pkg::result_t  wr_data1,
  output logic               has_room,
  output logic               rd_valid,
  input  logic               rd_ready,
  output ccfc_pkg::result_t  rd_data
);

  ccfc_pkg::result_t                 entries [ccfc_pkg::QueueDepth];
  logic [ccfc_pkg::PtrW-1:0]         wr_ptr;
  logic [ccfc_pkg::PtrW-1:0]         rd_ptr;
  logic [ccfc_pkg::CntW-1:0]         count;
  logic [ccfc_pkg::PtrW-1:0]         wr_ptr1;
  logic [ccfc_pkg::CntW-1:0]         n_push;
  logic                              pop;

  assign wr_ptr1  = wr_ptr + ccfc_pkg::PtrW'(1);
  assign pop      = rd_valid && rd_ready;
  assign n_push   = ccfc_pkg::CntW'(wr_en0) + ccfc_pkg::CntW'(wr_en1);
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  // room for the two results one byte can cause
  assign has_room = (count <= ccfc_pkg::CntW'(ccfc_pkg::QueueDepth - 2));

  // entry storage, up to two writes per cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < ccfc_pkg::QueueDepth; i++) begin
      if (wr_en0 && (wr_ptr == ccfc_pkg::PtrW'(i))) begin
        entries[i] <= wr_data0;
      end else if (wr_en1 && (wr_ptr1 == ccfc_pkg::PtrW'(i))) begin
        entries[i] <= wr_data1;
      end
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ccfc_pkg::PtrW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + ccfc_pkg::PtrW'(1);
      end
      count <= count + n_push - ccfc_pkg::CntW'(pop);
    end
  end

endmodule

// ===== src/conv_id_crc32c_frame_checker.sv =====
// a result is written into the output queue when its byte is accepted and offered from it
// throughput: one byte per cycle if s_tready; the byte marked last yields up to two results,
//   which drain through a four-entry output queue at one transaction per cycle on m_tready
// a byte is taken whenever the queue holds two or fewer results
// reset (rst, synchronous): empties the queue, position 0, crc all ones, id and tail cleared
module conv_id_crc32c_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] payload_byte, [39:8] conv_id, [41:40] status, zeros
  output logic        m_tuser,   // kind
  output logic        m_tlast    // run_end
);

  logic [3:0]  byte_position, byte_position_next;
  logic [31:0] crc_register, crc_register_next;
  logic [7:0]  tail_delay [4];
  logic [7:0]  tail_delay_next [4];
  logic [31:0] conv_capture, conv_capture_next;

  logic              accept;
  logic              in_header;
  logic              release_byte;
  logic [31:0]       trailer;
  logic [1:0]        status_code;
  ccfc_pkg::result_t payload_res, status_res;
  ccfc_pkg::result_t wr_data0, wr_data1;
  logic              wr_en0, wr_en1;
  logic              has_room;
  ccfc_pkg::result_t rd_data;

  assign s_tready = has_room;
  assign accept   = s_tvalid && s_tready;

  assign in_header    = (byte_position < 4'(ccfc_pkg::HeaderBytes));
  assign release_byte = !in_header && (byte_position >= 4'(ccfc_pkg::MinFrame));

  // per-byte state update
  always_comb begin
    crc_register_next = crc_register;
    conv_capture_next = conv_capture;
    for (int i = 0; i < 4; i++) begin
      tail_delay_next[i] = tail_delay[i];
    end
    if (in_header) begin
      crc_register_next = ccfc_pkg::crc_update(crc_register, s_tdata);
      conv_capture_next = {conv_capture[23:0], s_tdata};
    end else begin
      if (release_byte) begin
        crc_register_next = ccfc_pkg::crc_update(crc_register, tail_delay[0]);
      end
      tail_delay_next[0] = tail_delay[1];
      tail_delay_next[1] = tail_delay[2];
      tail_delay_next[2] = tail_delay[3];
      tail_delay_next[3] = s_tdata;
    end
    byte_position_next = (byte_position < 4'(ccfc_pkg::MinFrame)) ?
                         byte_position + 4'd1 : byte_position;
  end

  // end-of-datagram check
  assign trailer = {tail_delay_next[0], tail_delay_next[1],
                    tail_delay_next[2], tail_delay_next[3]};

  always_comb begin
    if (byte_position_next < 4'(ccfc_pkg::MinFrame)) begin
      status_code = ccfc_pkg::ST_SHORT;
    end else if (trailer == ~crc_register_next) begin
      status_code = ccfc_pkg::ST_OK;
    end else begin
      status_code = ccfc_pkg::ST_CRC_ERROR;
    end
  end

  // result items
  always_comb begin
    payload_res              = '0;
    payload_res.kind         = ccfc_pkg::KIND_PAYLOAD;
    payload_res.payload_byte = tail_delay[0];
    payload_res.run_end      = !s_tlast;

    status_res         = '0;
    status_res.kind    = ccfc_pkg::KIND_STATUS;
    status_res.conv_id = conv_capture_next;
    status_res.status  = status_code;
    status_res.run_end = 1'b1;
  end

  assign wr_en0   = accept && (release_byte || s_tlast);
  assign wr_en1   = accept && release_byte && s_tlast;
  assign wr_data0 = release_byte ? payload_res : status_res;
  assign wr_data1 = status_res;

  // datagram state, back to reset after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      crc_register  <= ccfc_pkg::CrcInit;
      conv_capture  <= '0;
      for (int i = 0; i < 4; i++) begin
        tail_delay[i] <= '0;
      end
    end else if (accept) begin
      if (s_tlast) begin
        byte_position <= '0;
        crc_register  <= ccfc_pkg::CrcInit;
        conv_capture  <= '0;
        for (int i = 0; i < 4; i++) begin
          tail_delay[i] <= '0;
        end
      end else begin
        byte_position <= byte_position_next;
        crc_register  <= crc_register_next;
        conv_capture  <= conv_capture_next;
        for (int i = 0; i < 4; i++) begin
          tail_delay[i] <= tail_delay_next[i];
        end
      end
    end
  end

  // output queue
  ccfc_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en0   (wr_en0),
    .wr_en1   (wr_en1),
    .wr_data0 (wr_data0),
    .wr_data1 (wr_data1),
    .has_room (has_room),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (rd_data)
  );

  assign m_tdata = {6'd0, rd_data.status, rd_data.conv_id, rd_data.payload_byte};
  assign m_tuser = rd_data.kind;
  assign m_tlast = rd_data.run_end;

endmodule
